/* sv/read_correction_confusion_counter_defines.svh */
// Assertion macros for the read correction confusion counter.
// Included by the top level; depends on nothing else.
`ifndef READ_CORRECTION_CONFUSION_COUNTER_DEFINES_SVH
`define READ_CORRECTION_CONFUSION_COUNTER_DEFINES_SVH

// check cond in the same cycle as trig
`define RCC_ASSERT_NOW(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("rcc assertion failed");

// check cond in the cycle after trig
`define RCC_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("rcc assertion failed");

`endif

/* sv/rcc_pkg.sv */
// Shared types and constants of the read correction confusion counter.
// No dependencies.
package rcc_pkg;

   localparam int BASE_WIDTH          = 8;
   localparam int TOTAL_WIDTH         = 48;
   localparam int COUNT_WIDTH_DEFAULT = 48;
   localparam int TOTAL_COUNT         = 7;
   localparam int RSP_FIELD_BITS      = TOTAL_COUNT * TOTAL_WIDTH + 2;
   localparam int RSP_DATA_WIDTH      = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int REQ_DATA_WIDTH      = 3 * BASE_WIDTH;

   typedef enum logic [1:0] {
      CLS_TN = 2'd0,
      CLS_FP = 2'd1,
      CLS_TP = 2'd2,
      CLS_FN = 2'd3
   } class_code_type;

   typedef struct packed {
      class_code_type cls;
      logic           has_error;
      logic           has_change;
   } position_class_type;

endpackage

/* sv/rcc_classify.sv */
// Case folding and confusion classification of one aligned base position.
// Depends on rcc_pkg.
module rcc_classify (
   input  logic [rcc_pkg::BASE_WIDTH-1:0] reference_base,
   input  logic [rcc_pkg::BASE_WIDTH-1:0] corrupted_base,
   input  logic [rcc_pkg::BASE_WIDTH-1:0] corrected_base,
   output rcc_pkg::position_class_type    pos_class
);

   localparam logic [rcc_pkg::BASE_WIDTH-1:0] LOWER_A    = 8'h61;
   localparam logic [rcc_pkg::BASE_WIDTH-1:0] LOWER_Z    = 8'h7a;
   localparam logic [rcc_pkg::BASE_WIDTH-1:0] CASE_SHIFT = 8'h20;

   function automatic logic [rcc_pkg::BASE_WIDTH-1:0] fold_upper(
      input logic [rcc_pkg::BASE_WIDTH-1:0] b
   );
      if (b >= LOWER_A && b <= LOWER_Z) begin
         return b - CASE_SHIFT;
      end
      return b;
   endfunction

   logic [rcc_pkg::BASE_WIDTH-1:0] ref_up;
   logic [rcc_pkg::BASE_WIDTH-1:0] bad_up;
   logic [rcc_pkg::BASE_WIDTH-1:0] fix_up;

   always_comb begin
      ref_up = fold_upper(reference_base);
      bad_up = fold_upper(corrupted_base);
      fix_up = fold_upper(corrected_base);
      pos_class.has_error  = (ref_up != bad_up);
      pos_class.has_change = (bad_up != fix_up);
      if (ref_up == bad_up) begin
         pos_class.cls = (bad_up == fix_up) ? rcc_pkg::CLS_TN : rcc_pkg::CLS_FP;
      end else begin
         pos_class.cls = (ref_up == fix_up) ? rcc_pkg::CLS_TP : rcc_pkg::CLS_FN;
      end
   end

endmodule

/* sv/rcc_counter.sv */
// Saturating event counter; exposes both the held and the next count.
// Depends on nothing.
module rcc_counter #(
   parameter int COUNT_WIDTH = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   incr,
   output logic [COUNT_WIDTH-1:0] count_ff,
   output logic [COUNT_WIDTH-1:0] count_in
);

   always_comb begin
      count_in = count_ff;
      if (incr && count_ff != {COUNT_WIDTH{1'b1}}) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

/* sv/read_correction_confusion_counter.sv */
// Read correction confusion counter: tallies TN/FP/TP/FN per base position.
// Depends on rcc_pkg, rcc_classify, rcc_counter and the defines header.
//
// Usage:
//   req_* carries one aligned position per word: tdata holds reference,
//   corrupted and corrected base (ASCII), tlast marks the last position of
//   a read. rsp_* gives one word per finished read with all running totals
//   (saturating) and the two per-read flags.
//   Throughput: one position per cycle while no read end waits for the result
//   register. A word accepted into the input register is classified there and
//   counted as it leaves; for a read end the totals and rsp_tvalid are then
//   registered in the result register. The combinational counter increment
//   between input and result register sets this rate.
//   Stall: positions without tlast keep flowing while a result waits. A
//   read end held in the input register waits until the result register
//   is taken, and req_tready drops only then.
//   Reset clears all counters, the per-read flags and both valid bits.
`include "read_correction_confusion_counter_defines.svh"
module read_correction_confusion_counter #(
   parameter int COUNT_WIDTH = rcc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] reference_base, [15:8] corrupted_base, [23:16] corrected_base
   input  logic [rcc_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [47:0] read_total, [95:48] unaltered_read_total,
   // [143:96] original_error_total, [191:144] true_negative_total,
   // [239:192] false_positive_total, [287:240] true_positive_total,
   // [335:288] false_negative_total, [336] read_had_errors,
   // [337] read_was_changed, rest zero
   output logic [rcc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   localparam int TW   = rcc_pkg::TOTAL_WIDTH;
   localparam int MAXW = (COUNT_WIDTH > TW) ? COUNT_WIDTH : TW;
   localparam int PADW = rcc_pkg::RSP_DATA_WIDTH - rcc_pkg::RSP_FIELD_BITS;
   localparam int BW   = rcc_pkg::BASE_WIDTH;

   // input register
   logic                               in_valid_ff;
   logic [rcc_pkg::REQ_DATA_WIDTH-1:0] in_data_ff;
   logic                               in_last_ff;
   logic                               in_go;

   // per-read flags
   logic err_read_ff, err_read_in;
   logic chg_read_ff, chg_read_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rcc_pkg::RSP_DATA_WIDTH-1:0] rsp_data_ff;
   logic                               rsp_free;

   rcc_pkg::position_class_type pos_class;

   logic [COUNT_WIDTH-1:0] reads_ff, reads_in;
   logic [COUNT_WIDTH-1:0] unalt_ff, unalt_in;
   logic [COUNT_WIDTH-1:0] errpos_ff, errpos_in;
   logic [COUNT_WIDTH-1:0] tn_ff, tn_in;
   logic [COUNT_WIDTH-1:0] fp_ff, fp_in;
   logic [COUNT_WIDTH-1:0] tp_ff, tp_in;
   logic [COUNT_WIDTH-1:0] fn_ff, fn_in;

   function automatic logic [TW-1:0] to_total(input logic [COUNT_WIDTH-1:0] c);
      logic [MAXW-1:0] w;
      w = MAXW'(c);
      return w[TW-1:0];
   endfunction

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   // a read end needs a free result slot; other positions always advance
   assign in_go      = in_valid_ff && (!in_last_ff || rsp_free);
   assign req_tready = !in_valid_ff || in_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   rcc_classify u_classify (
      .reference_base (in_data_ff[BW-1:0]),
      .corrupted_base (in_data_ff[2*BW-1:BW]),
      .corrected_base (in_data_ff[3*BW-1:2*BW]),
      .pos_class      (pos_class)
   );

   rcc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_reads (
      .clock(clock), .reset(reset), .incr(in_go && in_last_ff),
      .count_ff(reads_ff), .count_in(reads_in)
   );
   rcc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_unaltered (
      .clock(clock), .reset(reset),
      .incr(in_go && in_last_ff && err_read_in && !chg_read_in),
      .count_ff(unalt_ff), .count_in(unalt_in)
   );
   rcc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_errpos (
      .clock(clock), .reset(reset), .incr(in_go && pos_class.has_error),
      .count_ff(errpos_ff), .count_in(errpos_in)
   );
   rcc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_tn (
      .clock(clock), .reset(reset), .incr(in_go && pos_class.cls == rcc_pkg::CLS_TN),
      .count_ff(tn_ff), .count_in(tn_in)
   );
   rcc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_fp (
      .clock(clock), .reset(reset), .incr(in_go && pos_class.cls == rcc_pkg::CLS_FP),
      .count_ff(fp_ff), .count_in(fp_in)
   );
   rcc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_tp (
      .clock(clock), .reset(reset), .incr(in_go && pos_class.cls == rcc_pkg::CLS_TP),
      .count_ff(tp_ff), .count_in(tp_in)
   );
   rcc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_fn (
      .clock(clock), .reset(reset), .incr(in_go && pos_class.cls == rcc_pkg::CLS_FN),
      .count_ff(fn_ff), .count_in(fn_in)
   );

   // flags including the current position
   assign err_read_in = err_read_ff || (in_go && pos_class.has_error);
   assign chg_read_in = chg_read_ff || (in_go && pos_class.has_change);

   always_ff @(posedge clock) begin
      if (reset) begin
         err_read_ff <= 1'b0;
         chg_read_ff <= 1'b0;
      end else if (in_go && in_last_ff) begin
         err_read_ff <= 1'b0;
         chg_read_ff <= 1'b0;
      end else begin
         err_read_ff <= err_read_in;
         chg_read_ff <= chg_read_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (in_go && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_go && in_last_ff) begin
         rsp_data_ff <= {{PADW{1'b0}}, chg_read_in, err_read_in,
                         to_total(fn_in), to_total(tp_in), to_total(fp_in),
                         to_total(tn_in), to_total(errpos_in), to_total(unalt_in),
                         to_total(reads_in)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `RCC_ASSERT_NOW(a_end_stalls_input, clock, reset,
      in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_tready, !req_tready)
   `RCC_ASSERT_NEXT(a_end_gives_result, clock, reset,
      in_go && in_last_ff, rsp_tvalid)
   `RCC_ASSERT_NEXT(a_reads_monotonic, clock, reset,
      1'b1, reads_ff >= $past(reads_ff))
   `RCC_ASSERT_NOW(a_unaltered_bounded, clock, reset,
      1'b1, unalt_ff <= reads_ff)

endmodule

/* verif/tb_read_correction_confusion_counter.sv */
// Testbench for read_correction_confusion_counter: streams base positions and
// checks every per-read totals word against an in-bench tally of the same counts.
// Depends on rcc_pkg and the read_correction_confusion_counter RTL.
`timescale 1ns / 100ps

module tb_read_correction_confusion_counter;

   localparam int COUNT_WIDTH    = rcc_pkg::COUNT_WIDTH_DEFAULT;
   localparam int TOTAL_WIDTH    = rcc_pkg::TOTAL_WIDTH;
   localparam int REQ_DATA_WIDTH = rcc_pkg::REQ_DATA_WIDTH;
   localparam int RSP_DATA_WIDTH = rcc_pkg::RSP_DATA_WIDTH;
   localparam int MAX_GAP        = 13;
   localparam int IDLE_LIMIT     = 2000;
   localparam int DRAIN_TAIL     = 8;
   localparam int PAD_BITS       = RSP_DATA_WIDTH - rcc_pkg::RSP_FIELD_BITS;

   // mirrors rsp_tdata, first field in the highest bits
   typedef struct packed {
      logic [PAD_BITS-1:0]    pad;
      logic                   was_changed;
      logic                   had_errors;
      logic [TOTAL_WIDTH-1:0] fn_total;
      logic [TOTAL_WIDTH-1:0] tp_total;
      logic [TOTAL_WIDTH-1:0] fp_total;
      logic [TOTAL_WIDTH-1:0] tn_total;
      logic [TOTAL_WIDTH-1:0] error_total;
      logic [TOTAL_WIDTH-1:0] unaltered_total;
      logic [TOTAL_WIDTH-1:0] read_total;
   } read_totals_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // [7:0] reference_base, [15:8] corrupted_base, [23:16] corrected_base
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // [47:0] read_total ... [335:288] false_negative_total, [336] read_had_errors,
   // [337] read_was_changed, rest zero
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   // running tally of the block's counters
   logic [COUNT_WIDTH-1:0] reads_seen;
   logic [COUNT_WIDTH-1:0] unaltered_seen;
   logic [COUNT_WIDTH-1:0] errors_seen;
   logic [COUNT_WIDTH-1:0] class_tally [4];
   logic                   read_has_error;
   logic                   read_has_change;

   read_totals_type expected_totals [$];
   int              mismatch_count = 0;
   int              idle_cycles = 0;
   bit              no_idle = 1'b0;
   string           base_letters = "ACGTN";

   read_correction_confusion_counter #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] fold_case(logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   function automatic void clear_tally();
      reads_seen      = '0;
      unaltered_seen  = '0;
      errors_seen     = '0;
      foreach (class_tally[i]) class_tally[i] = '0;
      read_has_error  = 1'b0;
      read_has_change = 1'b0;
   endfunction

   // advance the tally by one accepted position; queue the totals at a read end
   function automatic void tally_position(logic [7:0] ref_b, logic [7:0] bad_b,
                                          logic [7:0] fix_b, logic last);
      logic [7:0]              r, b, f;
      rcc_pkg::class_code_type cls;
      read_totals_type         t;
      r = fold_case(ref_b);
      b = fold_case(bad_b);
      f = fold_case(fix_b);
      if (r == b) cls = (b == f) ? rcc_pkg::CLS_TN : rcc_pkg::CLS_FP;
      else        cls = (r == f) ? rcc_pkg::CLS_TP : rcc_pkg::CLS_FN;
      class_tally[cls] = bump(class_tally[cls]);
      if (r != b) begin
         errors_seen    = bump(errors_seen);
         read_has_error = 1'b1;
      end
      if (b != f) read_has_change = 1'b1;
      if (last) begin
         reads_seen = bump(reads_seen);
         if (read_has_error && !read_has_change) unaltered_seen = bump(unaltered_seen);
         t.pad             = '0;
         t.was_changed     = read_has_change;
         t.had_errors      = read_has_error;
         t.read_total      = TOTAL_WIDTH'(reads_seen);
         t.unaltered_total = TOTAL_WIDTH'(unaltered_seen);
         t.error_total     = TOTAL_WIDTH'(errors_seen);
         t.tn_total        = TOTAL_WIDTH'(class_tally[rcc_pkg::CLS_TN]);
         t.fp_total        = TOTAL_WIDTH'(class_tally[rcc_pkg::CLS_FP]);
         t.tp_total        = TOTAL_WIDTH'(class_tally[rcc_pkg::CLS_TP]);
         t.fn_total        = TOTAL_WIDTH'(class_tally[rcc_pkg::CLS_FN]);
         expected_totals.push_back(t);
         read_has_error  = 1'b0;
         read_has_change = 1'b0;
      end
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // send one position word; returns at the edge where it is accepted
   task automatic send_position(logic [7:0] ref_b, logic [7:0] bad_b,
                                logic [7:0] fix_b, logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {fix_b, bad_b, ref_b};
      req_tlast  <= last;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      tally_position(ref_b, bad_b, fix_b, last);
   endtask

   // hold the input until every queued totals word has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_totals.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] mix_case(logic [7:0] b);
      if (fold_case(b) >= 8'h41 && fold_case(b) <= 8'h5A && $urandom_range(0, 1))
         return b ^ 8'h20;
      return b;
   endfunction

   function automatic logic [7:0] random_base();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return mix_case(base_letters[$urandom_range(0, 4)]);
   endfunction

   // well-formed reads with random content and lengths
   task automatic send_random_reads(int n_items);
      int         sent;
      int         len;
      logic [7:0] r, b, f;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0) begin
               // raw byte noise
               r = 8'($urandom);
               b = 8'($urandom);
               f = 8'($urandom);
            end else begin
               r = random_base();
               b = ($urandom_range(0, 3) == 0) ? random_base() : mix_case(r);
               case ($urandom_range(0, 5))
                  0:       f = random_base();
                  1:       f = mix_case(r);
                  default: f = mix_case(b);
               endcase
            end
            send_position(r, b, f, i == len - 1);
         end
         sent += len;
      end
   endtask

   task automatic test_directed();
      send_position("A", "A", "A", 1'b0);        // true negative
      send_position("c", "C", "c", 1'b0);        // equal after case fold
      send_position("G", "G", "T", 1'b0);        // false positive
      send_position("T", "A", "t", 1'b0);        // true positive
      send_position("N", "A", "C", 1'b1);        // false negative, read changed
      send_position("G", "C", "C", 1'b1);        // one-position read left unaltered
      send_position(8'h00, 8'h00, 8'h00, 1'b1);  // clean read
      send_position(8'hFF, 8'h00, 8'hFF, 1'b0);
      send_position(8'h60, 8'h40, 8'h60, 1'b0);  // neighbors of 'a' and 'A' not folded
      send_position(8'h7B, 8'h5B, 8'h5B, 1'b0);  // neighbors of 'z' and 'Z' not folded
      send_position("a", "z", "Z", 1'b0);
      send_position(8'hE1, 8'hC1, 8'hE1, 1'b1);  // high bytes compared raw
      send_position("a", "A", "A", 1'b0);
      send_position("z", "Z", "{", 1'b1);
      send_position(8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_position(8'h55, 8'hAA, 8'hAA, 1'b0);
      send_position(8'hAA, 8'h55, 8'h55, 1'b1);  // errors, nothing changed
   endtask

   task automatic test_random_traffic(int n_items);
      send_random_reads(n_items);
   endtask

   task automatic test_drain_pause();
      send_random_reads(25);
      wait_for_results();
      send_random_reads(25);
   endtask

   task automatic test_steady_flow(int n_items);
      no_idle = 1'b1;
      send_random_reads(n_items);
      no_idle = 1'b0;
   endtask

   // result side: random stall before each word, none in steady stretches
   initial begin
      int stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   always @(posedge clock) begin
      read_totals_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = read_totals_type'(rsp_tdata);
         if (expected_totals.size() == 0) begin
            $display("%0t: unexpected totals word, expected none got %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_totals.pop_front();
            compare_field("read_total", want.read_total, got.read_total);
            compare_field("unaltered_read_total", want.unaltered_total, got.unaltered_total);
            compare_field("original_error_total", want.error_total, got.error_total);
            compare_field("true_negative_total", want.tn_total, got.tn_total);
            compare_field("false_positive_total", want.fp_total, got.fp_total);
            compare_field("true_positive_total", want.tp_total, got.tp_total);
            compare_field("false_negative_total", want.fn_total, got.fn_total);
            compare_field("read_had_errors", want.had_errors, got.had_errors);
            compare_field("read_was_changed", want.was_changed, got.was_changed);
            compare_field("padding", want.pad, got.pad);
         end
      end
   end

   // stop a hung run: count cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_read_correction_confusion_counter failed");
         $finish;
      end
   end

   initial begin
      clear_tally();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(300);
      test_drain_pause();
      test_steady_flow(150);
      test_random_traffic(250);
      wait_for_results();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_read_correction_confusion_counter passed");
      end else begin
         $display("tb_read_correction_confusion_counter failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/rcc_pkg.sv
sv/rcc_classify.sv
sv/rcc_counter.sv
sv/read_correction_confusion_counter.sv
verif/tb_read_correction_confusion_counter.sv
